[sv/bsc_pkg.sv]
// shared constants, types and constant functions of the beta suitability curve
package bsc_pkg;

   // default fraction bits of the suitability output
   localparam int FRAC_BITS_DEF = 15;
   // fraction bits of log2 values and of the exponent
   localparam int LOG_FRAC = 20;
   // fraction bits of normalized mantissas (Q1.30)
   localparam int MANT_BITS = 30;
   // width of a log2 value: 4 integer bits over LOG_FRAC fraction bits
   localparam int LOG_W = 4 + LOG_FRAC;
   // pipeline depth of one log2 unit
   localparam int LOG_LAT = LOG_FRAC + 1;

   // how a result is formed
   typedef enum logic [1:0] {
      PATH_ZERO,
      PATH_ERR,
      PATH_LINEAR,
      PATH_POWER
   } path_type;

   // data that rides alongside the log2 units
   typedef struct packed {
      path_type    path;
      logic [15:0] span_a;
      logic [15:0] span_b;
      logic [15:0] num1;
   } log_side_type;

   // data that rides alongside the divider
   typedef struct packed {
      path_type           path;
      logic signed [24:0] l1;
      logic               neg;
   } div_side_type;

   // data that rides alongside the exp2 product chain
   typedef struct packed {
      path_type             path;
      logic                 zero;
      logic [5:0]           shift;
      logic [LOG_FRAC-1:0]  frac;
      logic [15:0]          lin;
   } exp_side_type;

   // integer square root of a 64-bit value, used at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bitv > v) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-idx) in Q1.30 by repeated square roots
   function automatic logic [30:0] exp_root(input int idx);
      logic [63:0] r;
      r = 64'd2 << MANT_BITS;
      for (int j = 1; j <= LOG_FRAC; j++) begin
         if (j <= idx) r = isqrt64(r << MANT_BITS);
      end
      return r[30:0];
   endfunction

endpackage

[sv/beta_suitability_curve.sv]
// top level of the beta suitability curve pipeline
//
// usage: one item per cycle on the req_ channel while req_ready is high (env,
// max, opt, min, signed Q8.8); one result per item on the rsp_ channel
// (suitability in unsigned fixed point with FRAC_BITS fraction bits, plus order_error).
// throughput is one item per cycle while rsp_ready does not stall the pipe,
// set by the fully pipelined log2 units, the one-bit-per-stage divider and
// the exp2 product chain.
// every stage holds a valid bit; all stages advance together whenever the
// output register is empty or being taken, so a stall on rsp_ready freezes
// the whole pipe and req_ready drops in the same cycle. nothing is lost or
// repeated, and bubbles pass through freely.
// reset clears all valid bits; the data registers are not reset.
// results leave in the order the items came in.
module beta_suitability_curve import bsc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_env_value,
   input  logic signed [15:0] req_max_value,
   input  logic signed [15:0] req_opt_value,
   input  logic signed [15:0] req_min_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_suitability,
   output logic               rsp_order_error
);

   localparam int DIV_W = (FRAC_BITS + 16 > 41) ? FRAC_BITS + 16 : 41;
   localparam int LW    = DIV_W + 2;
   localparam int KW    = LW - LOG_FRAC + 1;
   localparam int DEPTH = 1 + LOG_LAT + 1 + 1 + DIV_W + 1 + 1 + LOG_FRAC + 1;

   logic en;
   logic valid_ff [DEPTH];

   // global advance: output empty or being taken
   assign en        = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // stage a: classify and form spans
   path_type    path_in;
   logic [15:0] a_in, b_in, n1_in, n2_in;
   log_side_type side_a_ff;
   logic [15:0]  n2_ff;

   always_comb begin
      a_in  = 16'(17'(req_max_value) - 17'(req_opt_value));
      b_in  = 16'(17'(req_opt_value) - 17'(req_min_value));
      n1_in = 16'(17'(req_max_value) - 17'(req_env_value));
      n2_in = 16'(17'(req_env_value) - 17'(req_min_value));
      if (req_max_value < req_opt_value || req_opt_value < req_min_value) begin
         path_in = PATH_ERR;
      end else if (req_env_value < req_min_value || req_env_value > req_max_value) begin
         path_in = PATH_ZERO;
      end else if (a_in == '0) begin
         path_in = PATH_ZERO;
      end else if (b_in == '0) begin
         path_in = PATH_LINEAR;
      end else if (n1_in == '0 || n2_in == '0) begin
         path_in = PATH_ZERO;
      end else begin
         path_in = PATH_POWER;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff.path   <= path_in;
         side_a_ff.span_a <= a_in;
         side_a_ff.span_b <= b_in;
         side_a_ff.num1   <= n1_in;
         n2_ff            <= n2_in;
      end
   end

   // four log2 units
   logic [LOG_W-1:0] log_n1, log_n2, log_a, log_b;

   bsc_log2 u_log_n1 (.clock(clock), .en(en), .n(side_a_ff.num1),   .log_val(log_n1));
   bsc_log2 u_log_n2 (.clock(clock), .en(en), .n(n2_ff),            .log_val(log_n2));
   bsc_log2 u_log_a  (.clock(clock), .en(en), .n(side_a_ff.span_a), .log_val(log_a));
   bsc_log2 u_log_b  (.clock(clock), .en(en), .n(side_a_ff.span_b), .log_val(log_b));

   log_side_type lside_ff [LOG_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         lside_ff[0] <= side_a_ff;
         for (int i = 1; i < LOG_LAT; i++) lside_ff[i] <= lside_ff[i-1];
      end
   end

   // stage d: log differences
   logic signed [24:0] d_ff, l1_ff;
   log_side_type       side_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff      <= $signed({1'b0, log_n2}) - $signed({1'b0, log_b});
         l1_ff     <= $signed({1'b0, log_n1}) - $signed({1'b0, log_a});
         side_d_ff <= lside_ff[LOG_LAT-1];
      end
   end

   // stage m: exponent numerator, or linear numerator
   logic signed [41:0] prod;
   logic [DIV_W-1:0]   num_ff;
   logic [15:0]        den_ff;
   div_side_type       side_m_ff;

   assign prod = $signed({1'b0, side_d_ff.span_b}) * d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (side_d_ff.path == PATH_LINEAR) begin
            num_ff <= DIV_W'(side_d_ff.num1) << FRAC_BITS;
            side_m_ff.neg <= 1'b0;
         end else begin
            num_ff <= DIV_W'(prod[41] ? 42'(-prod) : 42'(prod));
            side_m_ff.neg <= prod[41];
         end
         den_ff         <= side_d_ff.span_a;
         side_m_ff.path <= side_d_ff.path;
         side_m_ff.l1   <= l1_ff;
      end
   end

   // divider
   logic [DIV_W-1:0] quo;
   div_side_type     dside_ff [DIV_W];

   bsc_div #(.W(DIV_W)) u_div (
      .clock(clock),
      .en   (en),
      .num  (num_ff),
      .den  (den_ff),
      .quo  (quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dside_ff[0] <= side_m_ff;
         for (int i = 1; i < DIV_W; i++) dside_ff[i] <= dside_ff[i-1];
      end
   end

   // stage l: exponent sum clamped to zero, linear result saturated
   logic signed [LW-1:0] q_s, l_sum;
   logic [DIV_W-1:0]     lin_sat;
   logic signed [LW-1:0] l_ff;
   path_type             path_l_ff;
   logic [15:0]          lin_l_ff;

   always_comb begin
      q_s   = dside_ff[DIV_W-1].neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      l_sum = LW'(dside_ff[DIV_W-1].l1) + q_s;
      lin_sat = quo;
      if (lin_sat > (DIV_W'(1) << FRAC_BITS)) lin_sat = DIV_W'(1) << FRAC_BITS;
      if (lin_sat > DIV_W'(16'hFFFF)) lin_sat = DIV_W'(16'hFFFF);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff      <= (l_sum > 0) ? '0 : l_sum;
         path_l_ff <= dside_ff[DIV_W-1].path;
         lin_l_ff  <= lin_sat[15:0];
      end
   end

   // stage k: integer and fraction parts of the exponent
   logic [LW-1:0] lneg;
   logic [KW-1:0] k_val;
   exp_side_type  side_k_ff;

   always_comb begin
      lneg  = LW'(-l_ff);
      k_val = KW'((KW'(lneg >> LOG_FRAC)) + KW'(lneg[LOG_FRAC-1:0] != '0));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_k_ff.path  <= path_l_ff;
         side_k_ff.lin   <= lin_l_ff;
         side_k_ff.frac  <= LOG_FRAC'(-lneg[LOG_FRAC-1:0]);
         side_k_ff.zero  <= k_val >= KW'(32 + FRAC_BITS);
         side_k_ff.shift <= 6'(MANT_BITS - FRAC_BITS) + 6'(k_val);
      end
   end

   // exp2 product chain, one root constant per stage
   logic [30:0]  acc_ff  [LOG_FRAC];
   exp_side_type eside_ff [LOG_FRAC];

   for (genvar i = 0; i < LOG_FRAC; i++) begin : g_exp
      localparam logic [30:0] ROOT = exp_root(i + 1);
      logic [30:0]  acc_p;
      exp_side_type side_p;
      logic [61:0]  mul;
      if (i == 0) begin : g_first
         assign acc_p  = 31'(1) << MANT_BITS;
         assign side_p = side_k_ff;
      end else begin : g_next
         assign acc_p  = acc_ff[i-1];
         assign side_p = eside_ff[i-1];
      end
      assign mul = 62'(acc_p) * 62'(ROOT);
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[i]   <= side_p.frac[LOG_FRAC-1-i] ? mul[MANT_BITS +: 31] : acc_p;
            eside_ff[i] <= side_p;
         end
      end
   end

   // output stage: scale, saturate and select
   exp_side_type side_e;
   logic [30:0]  pow_s;
   logic [15:0]  suit_in;
   logic         err_in;
   logic [15:0]  suit_ff;
   logic         err_ff;

   assign side_e = eside_ff[LOG_FRAC-1];

   always_comb begin
      pow_s = acc_ff[LOG_FRAC-1] >> side_e.shift;
      if (side_e.zero) pow_s = '0;
      if (pow_s > (31'(1) << FRAC_BITS)) pow_s = 31'(1) << FRAC_BITS;
      if (pow_s > 31'(16'hFFFF)) pow_s = 31'(16'hFFFF);
      err_in  = 1'b0;
      suit_in = '0;
      unique case (side_e.path)
         PATH_ERR:    err_in  = 1'b1;
         PATH_LINEAR: suit_in = side_e.lin;
         PATH_POWER:  suit_in = pow_s[15:0];
         default:     suit_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         suit_ff <= suit_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_suitability = suit_ff;
   assign rsp_order_error = err_ff;

endmodule

[sv/bsc_log2.sv]
// pipelined log2 unit: one result bit per squaring stage
module bsc_log2 import bsc_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [15:0]      n,
   output logic [LOG_W-1:0] log_val
);

   logic [30:0]         m_ff    [LOG_LAT];
   logic [3:0]          msb_ff  [LOG_LAT];
   logic [LOG_FRAC-1:0] frac_ff [LOG_LAT];

   logic [3:0]  msb_in;
   logic [30:0] m0_in;

   // normalize: leading one and mantissa in Q1.30
   always_comb begin
      msb_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (n[i]) msb_in = 4'(i);
      end
      m0_in = 31'(n) << (5'(MANT_BITS) - 5'(msb_in));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]    <= m0_in;
         msb_ff[0]  <= msb_in;
         frac_ff[0] <= '0;
      end
   end

   // squaring stages, one fraction bit each
   for (genvar i = 1; i < LOG_LAT; i++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      logic        bit_in;
      logic [30:0] m_in;
      assign sq     = 62'(m_ff[i-1]) * 62'(m_ff[i-1]);
      assign t      = sq[MANT_BITS +: 32];
      assign bit_in = t[31];
      assign m_in   = bit_in ? t[31:1] : t[30:0];
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i]    <= m_in;
            msb_ff[i]  <= msb_ff[i-1];
            frac_ff[i] <= {frac_ff[i-1][LOG_FRAC-2:0], bit_in};
         end
      end
   end

   assign log_val = {msb_ff[LOG_LAT-1], frac_ff[LOG_LAT-1]};

endmodule

[sv/bsc_div.sv]
// pipelined restoring divider: one quotient bit per stage, 16-bit divisor
module bsc_div import bsc_pkg::*; #(
   parameter int W = 41
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] num,
   input  logic [15:0]  den,
   output logic [W-1:0] quo
);

   logic [15:0]  rem_ff [W];
   logic [W-1:0] nq_ff  [W];
   logic [15:0]  den_ff [W];

   for (genvar j = 0; j < W; j++) begin : g_step
      logic [15:0]  rem_p;
      logic [W-1:0] nq_p;
      logic [15:0]  den_p;
      logic [16:0]  trial;
      logic         take;
      logic [15:0]  rem_in;
      if (j == 0) begin : g_first
         assign rem_p = '0;
         assign nq_p  = num;
         assign den_p = den;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign nq_p  = nq_ff[j-1];
         assign den_p = den_ff[j-1];
      end
      // trial subtract of the divisor
      assign trial  = {rem_p, nq_p[W-1]};
      assign take   = trial >= {1'b0, den_p};
      assign rem_in = take ? 16'(trial - {1'b0, den_p}) : trial[15:0];
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            nq_ff[j]  <= {nq_p[W-2:0], take};
            den_ff[j] <= den_p;
         end
      end
   end

   assign quo = nq_ff[W-1];

endmodule
